/* hdl/ihl_pkg.sv */
// Shared types, constants and helpers of the Intel HEX image loader.
// Used by ihl_judge and intel_hex_image_loader_core; depends on nothing.
`default_nettype none
package ihl_pkg;

    localparam int IMAGE_BYTES_DEF  = 65536;
    localparam int RECORD_BYTES_DEF = 255;

    localparam int REC_OVERHEAD  = 5;
    localparam int LINE_SHORTEST = 1 + 2 * REC_OVERHEAD;
    localparam int LINE_LONGEST  = 1 + 2 * (REC_OVERHEAD + 255);

    localparam logic [9:0]  COUNT_CAP = 10'd1023;
    localparam logic [19:0] LINE_CAP  = 20'hFFFFF;

    // input commands
    localparam logic [1:0] CMD_TEXT = 2'd0;
    localparam logic [1:0] CMD_END  = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_LINE    = 2'd0;
    localparam logic [1:0] KIND_SUMMARY = 2'd1;
    localparam logic [1:0] KIND_READ    = 2'd2;

    // status codes
    localparam logic [3:0] ST_DATA      = 4'd0;
    localparam logic [3:0] ST_BLANK     = 4'd1;
    localparam logic [3:0] ST_ENTRY     = 4'd2;
    localparam logic [3:0] ST_BAD_LEN   = 4'd3;
    localparam logic [3:0] ST_BAD_ENTRY = 4'd4;
    localparam logic [3:0] ST_UNSUPP    = 4'd5;
    localparam logic [3:0] ST_EOF       = 4'd6;
    localparam logic [3:0] ST_MALFORMED = 4'd7;
    localparam logic [3:0] ST_NO_EOF    = 4'd8;

    // record types
    localparam logic [7:0] RT_DATA = 8'h00;
    localparam logic [7:0] RT_EOF  = 8'h01;
    localparam logic [7:0] RT_ESA  = 8'h02;
    localparam logic [7:0] RT_SSA  = 8'h03;
    localparam logic [7:0] RT_ELA  = 8'h04;
    localparam logic [7:0] RT_SLA  = 8'h05;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;

    typedef enum logic [1:0] {
        PH_START   = 2'd0,
        PH_RECORD  = 2'd1,
        PH_BAD     = 2'd2,
        PH_COMMENT = 2'd3
    } phase_t;

    typedef struct packed {
        logic [3:0]  status;
        logic        store;
        logic        set_entry;
        logic [15:0] entry;
    } judge_t;

    // {valid, value}
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
        else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
        return r;
    endfunction

endpackage
`default_nettype wire

/* hdl/ihl_judge.sv */
// Line-end verdict: length, count, bound, checksum and record type checks.
// Depends on ihl_pkg.
`default_nettype none
module ihl_judge (
    input  wire ihl_pkg::phase_t phase,
    input  wire logic [9:0]      char_count,
    input  wire logic [31:0]     header,
    input  wire logic [31:0]     data_word,
    input  wire logic [7:0]      checksum,
    output ihl_pkg::judge_t      verdict
);
    import ihl_pkg::*;

    logic [7:0]  cnt;
    logic [15:0] addr;
    logic [7:0]  rtype;
    logic [16:0] rec_end;
    logic [9:0]  expect_cnt;
    logic        shape_bad;

    assign cnt        = header[31:24];
    assign addr       = header[23:8];
    assign rtype      = header[7:0];
    assign rec_end    = {1'b0, addr} + {9'd0, cnt};
    assign expect_cnt = ((char_count - 10'd1) >> 1) - 10'(REC_OVERHEAD);

    always_comb
    begin
        shape_bad = (char_count < 10'(LINE_SHORTEST)) || (char_count > 10'(LINE_LONGEST))
                    || !char_count[0] || ({2'd0, cnt} != expect_cnt)
                    || (rec_end > 17'h10000) || (checksum != 8'd0);
        verdict.status    = ST_MALFORMED;
        verdict.store     = 1'b0;
        verdict.set_entry = 1'b0;
        verdict.entry     = data_word[15:0];
        case (phase)
            PH_START, PH_COMMENT: verdict.status = ST_BLANK;
            PH_BAD:               verdict.status = ST_MALFORMED;
            PH_RECORD:
            begin
                if (!shape_bad)
                begin
                    case (rtype)
                        RT_DATA:
                        begin
                            verdict.status = ST_DATA;
                            verdict.store  = (cnt != 8'd0);
                        end
                        RT_EOF: verdict.status = (cnt != 8'd0) ? ST_BAD_LEN : ST_EOF;
                        RT_SSA, RT_SLA:
                        begin
                            if (cnt != 8'd4) verdict.status = ST_BAD_LEN;
                            else if (data_word[31:16] != 16'd0) verdict.status = ST_BAD_ENTRY;
                            else
                            begin
                                verdict.status    = ST_ENTRY;
                                verdict.set_entry = 1'b1;
                            end
                        end
                        RT_ESA, RT_ELA: verdict.status = ST_UNSUPP;
                        default: verdict.status = ST_MALFORMED;
                    endcase
                end
            end
            default: verdict.status = ST_MALFORMED;
        endcase
    end

endmodule
`default_nettype wire

/* hdl/intel_hex_image_loader_core.sv */
// Intel HEX image loader, top level: parser, record buffer, image memory.
// Depends on ihl_pkg and ihl_judge.
//
// Usage:
//  Slave channel s_*: tuser = cmd (0 text character, 1 end of input,
//  2 read image byte); tdata = char_code, read_offset.
//  Master channel m_*: tuser = kind, tlast = last result of the input
//  transfer, tdata = status, line, size, base, entry, read data.
//  After reset the image memory is filled with 0xFF, one byte a cycle,
//  while s_tready stays low.
//  A line end first takes the verdict, then copies a stored data record
//  from the record buffer to the image memory (one port each), then
//  gives its results. A read uses a registered memory read.
//  Results go through one output register; a stalled receiver holds it,
//  while characters that give no result are still taken.
//  End of input after parsing has ended repeats the summary.
`default_nettype none
module intel_hex_image_loader_core #(
    parameter int IMAGE_BYTES  = ihl_pkg::IMAGE_BYTES_DEF,
    parameter int RECORD_BYTES = ihl_pkg::RECORD_BYTES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // char_code[7:0], read_offset[23:8]
    input  wire logic [1:0]  s_tuser,   // cmd
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [87:0]      m_tdata,   // status[3:0], line_number[23:4],
                                        // image_size[40:24], image_base[56:41],
                                        // entry_point[72:57], read_data[80:73], zero pad
    output logic [1:0]       m_tuser,   // kind
    output logic             m_tlast    // last_of_run
);
    import ihl_pkg::*;

    localparam int IMG_AW = $clog2(IMAGE_BYTES);
    localparam int REC_AW = $clog2(RECORD_BYTES);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_COPY  = 6'b000100,
        S_LINE  = 6'b001000,
        S_SUMM  = 6'b010000,
        S_READ  = 6'b100000
    } state_t;

    state_t state_reg;

    // memories
    logic [7:0] img_mem [IMAGE_BYTES];
    logic [7:0] rec_mem [RECORD_BYTES];
    logic [7:0] img_q_reg, rec_q_reg;

    // parser state
    phase_t      phase_reg;
    logic [9:0]  count_reg;
    logic [4:0]  nib_reg;
    logic [7:0]  csum_reg;
    logic [31:0] header_reg;
    logic [31:0] data_word_reg;
    logic        cr_reg;
    logic [16:0] low_reg, high_reg;
    logic [15:0] entry_reg;
    logic [19:0] line_reg;
    logic        done_reg;
    logic [3:0]  final_status_reg;
    logic [19:0] final_line_reg;

    // sequencing
    logic [IMG_AW-1:0] clr_reg;
    logic [15:0] copy_addr_reg;
    logic [7:0]  copy_cnt_reg;
    logic [8:0]  copy_rd_reg;
    logic        wr_pend_reg;
    logic [15:0] wr_addr_reg;
    logic [3:0]  line_stat_reg;
    logic [19:0] line_num_reg;
    logic        summ_pend_reg;
    logic [3:0]  summ_status_reg;
    logic [19:0] summ_line_reg;
    logic        rd_hit_reg;

    // output register
    logic        m_valid_reg;
    logic [1:0]  m_kind_reg;
    logic [3:0]  m_status_reg;
    logic [19:0] m_line_reg;
    logic [16:0] m_size_reg;
    logic [15:0] m_base_reg;
    logic [15:0] m_entry_reg;
    logic [7:0]  m_rd_reg;
    logic        m_last_reg;

    logic [1:0]  cmd;
    logic [7:0]  ch;
    logic [15:0] offset;
    logic        accept, out_free, load_out;

    assign cmd      = s_tuser;
    assign ch       = s_tdata[7:0];
    assign offset   = s_tdata[23:8];
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    // a result is loaded into the output register this cycle
    assign load_out = out_free && (state_reg == S_LINE || state_reg == S_SUMM ||
                                   state_reg == S_READ);

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {7'd0, m_rd_reg, m_entry_reg, m_base_reg, m_size_reg,
                       m_line_reg, m_status_reg};

    // current summary
    logic [16:0] sum_size;
    logic [15:0] sum_base, sum_entry;
    always_comb
    begin
        if (low_reg < high_reg)
        begin
            sum_size  = high_reg - low_reg;
            sum_base  = low_reg[15:0];
            sum_entry = ({1'b0, entry_reg} >= low_reg && {1'b0, entry_reg} < high_reg)
                        ? entry_reg : low_reg[15:0];
        end
        else
        begin
            sum_size  = 17'd0;
            sum_base  = 16'd0;
            sum_entry = 16'd0;
        end
    end

    // character feed: a pending CR first, then the new character
    phase_t      ph_a, ph_next;
    logic [9:0]  cnt_a, cnt_next;
    logic [4:0]  nib_next, hv;
    logic [7:0]  csum_next, byte_v;
    logic [31:0] header_next, data_word_next;
    logic [9:0]  idx;
    logic        rec_we;
    logic [REC_AW-1:0] rec_waddr;

    always_comb
    begin
        ph_a  = phase_reg;
        cnt_a = count_reg;
        if (cr_reg)
        begin
            cnt_a = (count_reg == COUNT_CAP) ? COUNT_CAP : count_reg + 10'd1;
            if (phase_reg == PH_START || phase_reg == PH_RECORD) ph_a = PH_BAD;
        end
        ph_next        = ph_a;
        cnt_next       = cnt_a;
        nib_next       = nib_reg;
        csum_next      = csum_reg;
        header_next    = header_reg;
        data_word_next = data_word_reg;
        rec_we         = 1'b0;
        hv             = hex_value(ch);
        byte_v         = {nib_reg[3:0], hv[3:0]};
        idx            = 10'd0;
        rec_waddr      = '0;
        if (ch != CH_CR)
        begin
            cnt_next = (cnt_a == COUNT_CAP) ? COUNT_CAP : cnt_a + 10'd1;
            idx      = (cnt_next - 10'd3) >> 1;
            case (ph_a)
                PH_START:
                    ph_next = (ch == CH_COLON) ? PH_RECORD : (ch == CH_SEMI) ? PH_COMMENT : PH_BAD;
                PH_RECORD:
                begin
                    if (cnt_next > 10'(LINE_LONGEST) || !hv[4]) ph_next = PH_BAD;
                    else if (!nib_reg[4]) nib_next = {1'b1, hv[3:0]};
                    else
                    begin
                        nib_next  = 5'd0;
                        csum_next = csum_reg + byte_v;
                        if (idx < 10'd4)
                            header_next[8*(3-idx[1:0]) +: 8] = byte_v;
                        else if (idx - 10'd4 < 10'(RECORD_BYTES))
                        begin
                            rec_we    = 1'b1;
                            rec_waddr = REC_AW'(idx - 10'd4);
                            if (idx < 10'd8) data_word_next[8*(3-idx[1:0]) +: 8] = byte_v;
                        end
                    end
                end
                default: ph_next = ph_a;
            endcase
        end
    end

    judge_t verdict;
    ihl_judge u_judge (
        .phase      (phase_reg),
        .char_count (count_reg),
        .header     (header_reg),
        .data_word  (data_word_reg),
        .checksum   (csum_reg),
        .verdict    (verdict)
    );

    logic        is_lf, finish, term;
    logic [19:0] line_inc;
    logic [16:0] rec_end;
    logic [16:0] rd_sum;
    assign is_lf    = (ch == CH_LF);
    assign finish   = accept && !done_reg && ((cmd == CMD_TEXT && is_lf) ||
                      (cmd == CMD_END && (count_reg != 10'd0 || cr_reg)));
    assign term     = (verdict.status == ST_EOF) || (verdict.status == ST_MALFORMED);
    assign line_inc = (line_reg == LINE_CAP) ? LINE_CAP : line_reg + 20'd1;
    assign rec_end  = {1'b0, header_reg[23:8]} + {9'd0, header_reg[31:24]};
    assign rd_sum   = {1'b0, sum_base} + {1'b0, offset};

    // memory control
    logic              img_we, img_re, rec_re;
    logic [IMG_AW-1:0] img_waddr, img_raddr;
    logic [7:0]        img_wdata;
    assign img_we    = (state_reg == S_CLEAR) || wr_pend_reg;
    assign img_waddr = (state_reg == S_CLEAR) ? clr_reg : IMG_AW'(wr_addr_reg);
    assign img_wdata = (state_reg == S_CLEAR) ? 8'hFF : rec_q_reg;
    assign img_re    = accept && (cmd == CMD_READ);
    assign img_raddr = IMG_AW'(rd_sum);
    assign rec_re    = (state_reg == S_COPY) && (copy_rd_reg < {1'b0, copy_cnt_reg});

    always_ff @(posedge clk)
    begin
        if (img_we) img_mem[img_waddr] <= img_wdata;
        if (img_re) img_q_reg <= img_mem[img_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (accept && cmd == CMD_TEXT && !done_reg && !is_lf && rec_we)
            rec_mem[rec_waddr] <= byte_v;
        if (rec_re) rec_q_reg <= rec_mem[REC_AW'(copy_rd_reg)];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            clr_reg          <= '0;
            phase_reg        <= PH_START;
            count_reg        <= 10'd0;
            nib_reg          <= 5'd0;
            csum_reg         <= 8'd0;
            header_reg       <= 32'd0;
            data_word_reg    <= 32'd0;
            cr_reg           <= 1'b0;
            low_reg          <= 17'h10000;
            high_reg         <= 17'd0;
            entry_reg        <= 16'd0;
            line_reg         <= 20'd1;
            done_reg         <= 1'b0;
            final_status_reg <= 4'd0;
            final_line_reg   <= 20'd0;
            copy_addr_reg    <= 16'd0;
            copy_cnt_reg     <= 8'd0;
            copy_rd_reg      <= 9'd0;
            wr_pend_reg      <= 1'b0;
            wr_addr_reg      <= 16'd0;
            line_stat_reg    <= 4'd0;
            line_num_reg     <= 20'd0;
            summ_pend_reg    <= 1'b0;
            summ_status_reg  <= 4'd0;
            summ_line_reg    <= 20'd0;
            rd_hit_reg       <= 1'b0;
            m_valid_reg      <= 1'b0;
            m_kind_reg       <= 2'd0;
            m_status_reg     <= 4'd0;
            m_line_reg       <= 20'd0;
            m_size_reg       <= 17'd0;
            m_base_reg       <= 16'd0;
            m_entry_reg      <= 16'd0;
            m_rd_reg         <= 8'd0;
            m_last_reg       <= 1'b0;
        end
        else
        begin
            if (load_out) m_valid_reg <= 1'b1;
            else if (m_tready) m_valid_reg <= 1'b0;
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + IMG_AW'(1);
                    if (clr_reg == IMG_AW'(IMAGE_BYTES - 1)) state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (finish)
                    begin
                        line_num_reg  <= line_reg;
                        line_stat_reg <= verdict.status;
                        if (verdict.status == ST_MALFORMED)
                        begin
                            low_reg   <= 17'h10000;
                            high_reg  <= 17'd0;
                            entry_reg <= 16'd0;
                        end
                        if (verdict.set_entry) entry_reg <= verdict.entry;
                        if (verdict.store)
                        begin
                            if ({1'b0, header_reg[23:8]} < low_reg)
                                low_reg <= {1'b0, header_reg[23:8]};
                            if (rec_end > high_reg) high_reg <= rec_end;
                            copy_addr_reg <= header_reg[23:8];
                            copy_cnt_reg  <= header_reg[31:24];
                            copy_rd_reg   <= 9'd0;
                        end
                        phase_reg  <= PH_START;
                        count_reg  <= 10'd0;
                        nib_reg    <= 5'd0;
                        csum_reg   <= 8'd0;
                        header_reg <= 32'd0;
                        cr_reg     <= 1'b0;
                        line_reg   <= line_inc;
                        if (term)
                        begin
                            done_reg         <= 1'b1;
                            final_status_reg <= verdict.status;
                            final_line_reg   <= line_reg;
                            summ_status_reg  <= verdict.status;
                            summ_line_reg    <= line_reg;
                            summ_pend_reg    <= 1'b1;
                        end
                        else if (cmd == CMD_END)
                        begin
                            done_reg         <= 1'b1;
                            final_status_reg <= ST_NO_EOF;
                            final_line_reg   <= line_inc;
                            summ_status_reg  <= ST_NO_EOF;
                            summ_line_reg    <= line_inc;
                            summ_pend_reg    <= 1'b1;
                        end
                        else summ_pend_reg <= 1'b0;
                        state_reg <= verdict.store ? S_COPY : S_LINE;
                    end
                    else if (accept)
                    begin
                        case (cmd)
                            CMD_TEXT:
                            begin
                                if (!done_reg)
                                begin
                                    phase_reg     <= ph_next;
                                    count_reg     <= cnt_next;
                                    nib_reg       <= nib_next;
                                    csum_reg      <= csum_next;
                                    header_reg    <= header_next;
                                    data_word_reg <= data_word_next;
                                    cr_reg        <= (ch == CH_CR);
                                end
                            end
                            CMD_END:
                            begin
                                if (done_reg)
                                begin
                                    summ_status_reg <= final_status_reg;
                                    summ_line_reg   <= final_line_reg;
                                end
                                else
                                begin
                                    done_reg         <= 1'b1;
                                    final_status_reg <= ST_NO_EOF;
                                    final_line_reg   <= line_reg;
                                    summ_status_reg  <= ST_NO_EOF;
                                    summ_line_reg    <= line_reg;
                                end
                                state_reg <= S_SUMM;
                            end
                            CMD_READ:
                            begin
                                rd_hit_reg <= ({1'b0, offset} < sum_size);
                                state_reg  <= S_READ;
                            end
                            default: ;
                        endcase
                    end
                end
                S_COPY:
                begin
                    // read stage then write stage, one byte a cycle
                    if (rec_re)
                    begin
                        copy_rd_reg <= copy_rd_reg + 9'd1;
                        wr_pend_reg <= 1'b1;
                        wr_addr_reg <= copy_addr_reg + {7'd0, copy_rd_reg};
                    end
                    else
                    begin
                        wr_pend_reg <= 1'b0;
                        if (!wr_pend_reg) state_reg <= S_LINE;
                    end
                end
                S_LINE:
                begin
                    if (out_free)
                    begin
                        m_kind_reg   <= KIND_LINE;
                        m_status_reg <= line_stat_reg;
                        m_line_reg   <= line_num_reg;
                        m_size_reg   <= sum_size;
                        m_base_reg   <= sum_base;
                        m_entry_reg  <= sum_entry;
                        m_rd_reg     <= 8'd0;
                        m_last_reg   <= !summ_pend_reg;
                        state_reg    <= summ_pend_reg ? S_SUMM : S_IDLE;
                    end
                end
                S_SUMM:
                begin
                    if (out_free)
                    begin
                        m_kind_reg    <= KIND_SUMMARY;
                        m_status_reg  <= summ_status_reg;
                        m_line_reg    <= summ_line_reg;
                        m_size_reg    <= sum_size;
                        m_base_reg    <= sum_base;
                        m_entry_reg   <= sum_entry;
                        m_rd_reg      <= 8'd0;
                        m_last_reg    <= 1'b1;
                        summ_pend_reg <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                S_READ:
                begin
                    if (out_free)
                    begin
                        m_kind_reg   <= KIND_READ;
                        m_status_reg <= 4'd0;
                        m_line_reg   <= 20'd0;
                        m_size_reg   <= sum_size;
                        m_base_reg   <= sum_base;
                        m_entry_reg  <= sum_entry;
                        m_rd_reg     <= rd_hit_reg ? img_q_reg : 8'hFF;
                        m_last_reg   <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

/* tb/sv/intel_hex_image_loader_core_tb.sv */
// Self-checking testbench of intel_hex_image_loader_core: Intel HEX text in,
// line statuses, summaries and image reads out, checked against an in-bench
// model of the loader. Depends on ihl_pkg and the loader RTL.
`timescale 1ns / 1ps
`default_nettype none
module intel_hex_image_loader_core_tb;
    import ihl_pkg::*;

    typedef struct {
        logic [1:0]  cmd;
        logic [7:0]  ch;
        logic [15:0] off;
    } hex_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  status;
        logic [19:0] line;
        logic [16:0] size;
        logic [15:0] base;
        logic [15:0] entry;
        logic [7:0]  rd;
        logic        last;
    } loader_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [87:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    intel_hex_image_loader_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    hex_item_t      text_q[$];      // items waiting to be offered
    loader_result_t expected_q[$];  // results still owed by the loader
    hex_item_t      cur_item;
    bit             offering;
    int             send_idle_pct;
    int             recv_stall_pct;
    int             hold_left;
    int             errors;

    // ---------------- loader model state ----------------
    logic [7:0]  img_mem[65536];
    logic [7:0]  rec_buf[255];
    logic [31:0] rec_hdr;
    int          n_chars;
    logic [4:0]  nibble;
    logic [7:0]  csum;
    phase_t      phase;
    int          lo_addr;
    int          hi_end;
    int          entry_addr;
    int          line_no;
    bit          done;
    bit          cr_held;
    logic [3:0]  final_st;
    int          final_line;

    function automatic int digit_of(logic [7:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "A" && c <= "F") return c - "A" + 10;
        if (c >= "a" && c <= "f") return c - "a" + 10;
        return -1;
    endfunction

    function automatic void add_result(logic [1:0] k, logic [3:0] st, int ln,
                                       logic [7:0] rd);
        loader_result_t r;
        r.kind = k;
        r.status = st;
        r.line = ln[19:0];
        r.rd = rd;
        r.last = 1'b0;
        if (lo_addr < hi_end) begin
            r.size = 17'(hi_end - lo_addr);
            r.base = 16'(lo_addr);
            r.entry = (entry_addr >= lo_addr && entry_addr < hi_end) ?
                      16'(entry_addr) : 16'(lo_addr);
        end
        else begin
            r.size = '0;
            r.base = '0;
            r.entry = '0;
        end
        expected_q.push_back(r);
    endfunction

    function automatic void take_char(logic [7:0] c);
        int v;
        int idx;
        logic [7:0] b;
        if (n_chars < 1023) n_chars++;
        if (phase == PH_START) begin
            phase = (c == CH_COLON) ? PH_RECORD : (c == CH_SEMI) ? PH_COMMENT : PH_BAD;
            return;
        end
        if (phase != PH_RECORD) return;
        if (n_chars > LINE_LONGEST) begin
            phase = PH_BAD;
            return;
        end
        v = digit_of(c);
        if (v < 0) begin
            phase = PH_BAD;
            return;
        end
        if (!nibble[4]) begin
            nibble = {1'b1, 4'(v)};
            return;
        end
        b = {nibble[3:0], 4'(v)};
        idx = (n_chars - 3) / 2;
        nibble = '0;
        csum = csum + b;
        if (idx < 4) rec_hdr |= 32'(b) << (8 * (3 - idx));
        else if (idx - 4 < 255) rec_buf[idx - 4] = b;
    endfunction

    function automatic logic [3:0] record_verdict();
        int cnt;
        int addr;
        logic [7:0] rtype;
        cnt = int'(rec_hdr[31:24]);
        addr = int'(rec_hdr[23:8]);
        rtype = rec_hdr[7:0];
        if (n_chars < LINE_SHORTEST || n_chars > LINE_LONGEST || n_chars % 2 == 0)
            return ST_MALFORMED;
        if (cnt != (n_chars - 1) / 2 - REC_OVERHEAD) return ST_MALFORMED;
        if (addr + cnt > 65536) return ST_MALFORMED;
        if (csum != 8'd0) return ST_MALFORMED;
        case (rtype)
            RT_DATA:
            begin
                for (int i = 0; i < cnt; i++) img_mem[(addr + i) & 16'hFFFF] = rec_buf[i];
                if (cnt > 0) begin
                    if (addr < lo_addr) lo_addr = addr;
                    if (addr + cnt > hi_end) hi_end = addr + cnt;
                end
                return ST_DATA;
            end
            RT_EOF: return (cnt > 0) ? ST_BAD_LEN : ST_EOF;
            RT_SSA, RT_SLA:
            begin
                if (cnt != 4) return ST_BAD_LEN;
                if (rec_buf[0] != 0 || rec_buf[1] != 0) return ST_BAD_ENTRY;
                entry_addr = int'({rec_buf[2], rec_buf[3]});
                return ST_ENTRY;
            end
            RT_ESA, RT_ELA: return ST_UNSUPP;
            default: return ST_MALFORMED;
        endcase
    endfunction

    function automatic void close_line();
        logic [3:0] st;
        if (phase == PH_START || phase == PH_COMMENT) st = ST_BLANK;
        else if (phase == PH_BAD) st = ST_MALFORMED;
        else st = record_verdict();
        if (st == ST_MALFORMED) begin
            lo_addr = 65536;
            hi_end = 0;
            entry_addr = 0;
        end
        add_result(KIND_LINE, st, line_no, 8'd0);
        if (st == ST_EOF || st == ST_MALFORMED) begin
            add_result(KIND_SUMMARY, st, line_no, 8'd0);
            done = 1'b1;
            final_st = st;
            final_line = line_no;
        end
        rec_hdr = '0;
        n_chars = 0;
        nibble = '0;
        csum = '0;
        phase = PH_START;
        cr_held = 1'b0;
        if (line_no < LINE_CAP) line_no++;
    endfunction

    // works out what one accepted transfer must produce
    function automatic void predict_loader(hex_item_t it);
        int n_before;
        int sz;
        int base;
        logic [7:0] rd;
        n_before = expected_q.size();
        if (it.cmd == CMD_TEXT) begin
            if (!done) begin
                if (it.ch == CH_LF) close_line();
                else begin
                    if (cr_held) begin
                        cr_held = 1'b0;
                        take_char(CH_CR);
                    end
                    if (it.ch == CH_CR) cr_held = 1'b1;
                    else take_char(it.ch);
                end
            end
        end
        else if (it.cmd == CMD_END) begin
            if (done) add_result(KIND_SUMMARY, final_st, final_line, 8'd0);
            else begin
                if (n_chars > 0 || cr_held) close_line();
                if (!done) begin
                    add_result(KIND_SUMMARY, ST_NO_EOF, line_no, 8'd0);
                    done = 1'b1;
                    final_st = ST_NO_EOF;
                    final_line = line_no;
                end
            end
        end
        else if (it.cmd == CMD_READ) begin
            sz = (lo_addr < hi_end) ? hi_end - lo_addr : 0;
            base = (lo_addr < hi_end) ? lo_addr : 0;
            rd = 8'hFF;
            if (it.off < sz) rd = img_mem[(base + it.off) & 16'hFFFF];
            add_result(KIND_READ, 4'd0, 0, rd);
        end
        if (expected_q.size() > n_before) expected_q[$].last = 1'b1;
    endfunction

    // ---------------- clock, reset, limit ----------------
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end

    // ---------------- driver: one item per accepted transfer ----------------
    always @(posedge clk)
    begin
        if (s_tvalid && s_tready) begin
            predict_loader(cur_item);
            offering = 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && !offering && text_q.size() > 0 &&
            $urandom_range(99) >= send_idle_pct) begin
            cur_item = text_q.pop_front();
            offering = 1'b1;
        end
        s_tvalid <= offering;
        s_tuser  <= offering ? cur_item.cmd : 2'd0;
        s_tdata  <= offering ? {cur_item.off, cur_item.ch} : 24'd0;
    end

    // ---------------- monitor ----------------
    always @(negedge clk)
    begin
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        loader_result_t exp_r;
        loader_result_t got;
        if (m_tvalid && m_tready) begin
            got.kind = m_tuser;
            got.status = m_tdata[3:0];
            got.line = m_tdata[23:4];
            got.size = m_tdata[40:24];
            got.base = m_tdata[56:41];
            got.entry = m_tdata[72:57];
            got.rd = m_tdata[80:73];
            got.last = m_tlast;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("%t unexpected result kind %0d status %0d", $realtime,
                             got.kind, got.status);
            end
            else begin
                exp_r = expected_q.pop_front();
                if (got != exp_r) begin
                    errors++;
                    if (errors <= 10)
                        $display({"%t mismatch: exp k%0d st%0d ln%0d sz%0d b%h e%h rd%h l%0d",
                                  " / got k%0d st%0d ln%0d sz%0d b%h e%h rd%h l%0d"},
                                 $realtime, exp_r.kind, exp_r.status, exp_r.line,
                                 exp_r.size, exp_r.base, exp_r.entry, exp_r.rd, exp_r.last,
                                 got.kind, got.status, got.line, got.size, got.base,
                                 got.entry, got.rd, got.last);
                end
            end
        end
    end

    // ---------------- stimulus ----------------
    logic [7:0] payload[$];

    task automatic add_item(logic [1:0] cmd, logic [7:0] ch, logic [15:0] off);
        hex_item_t it;
        it.cmd = cmd;
        it.ch = ch;
        it.off = off;
        text_q.push_back(it);
    endtask

    task automatic add_char(logic [7:0] ch);
        add_item(CMD_TEXT, ch, 16'($urandom));
    endtask

    task automatic add_hex(logic [7:0] b);
        logic [3:0] n;
        for (int k = 1; k >= 0; k--) begin
            n = b[4*k +: 4];
            if (n < 10) add_char(8'("0" + n));
            else add_char(8'(($urandom_range(1) ? "A" : "a") + n - 10));
        end
    endtask

    task automatic end_line();
        if ($urandom_range(3) == 0) add_char(CH_CR);
        add_char(CH_LF);
    endtask

    // one record built from payload; bad_sum spoils the checksum
    task automatic add_record(int addr, logic [7:0] rtype, bit bad_sum);
        logic [7:0] sum;
        logic [7:0] hdr[4];
        hdr = '{8'(payload.size()), 8'(addr >> 8), 8'(addr), rtype};
        sum = 0;
        add_char(CH_COLON);
        foreach (hdr[i]) begin
            add_hex(hdr[i]);
            sum += hdr[i];
        end
        foreach (payload[i]) begin
            add_hex(payload[i]);
            sum += payload[i];
        end
        add_hex(8'(-sum) ^ (bad_sum ? 8'h01 : 8'h00));
        end_line();
    endtask

    task automatic fill_payload(int cnt);
        payload.delete();
        repeat (cnt) payload.push_back(8'($urandom));
    endtask

    task automatic add_entry(logic [7:0] rtype, logic [7:0] b0, logic [15:0] ea);
        payload = '{8'h00, b0, ea[15:8], ea[7:0]};
        add_record(0, rtype, 1'b0);
    endtask

    task automatic add_comment();
        add_char(CH_SEMI);
        repeat ($urandom_range(12)) begin
            logic [7:0] c;
            c = 8'($urandom);
            if (c == CH_LF) c = 8'hFF;
            add_char(c);
        end
        end_line();
    endtask

    task automatic add_read();
        add_item(CMD_READ, 8'($urandom),
                 $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(64)));
    endtask

    task automatic wait_drained();
        while (text_q.size() > 0 || offering || expected_q.size() > 0) @(posedge clk);
    endtask

    task automatic set_idling(int grp);
        case (grp % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
            default: begin send_idle_pct = 26; recv_stall_pct = 26; end
        endcase
    endtask

    task automatic random_line();
        int cnt;
        int pick;
        pick = $urandom_range(19);
        cnt = ($urandom_range(15) == 0) ? $urandom_range(40) : $urandom_range(16);
        if (pick < 12) begin
            fill_payload(cnt);
            add_record($urandom_range(65536 - cnt), RT_DATA, 1'b0);
        end
        else if (pick < 14)
            add_entry($urandom_range(1) ? RT_SSA : RT_SLA,
                      ($urandom_range(3) == 0) ? 8'($urandom) : 8'h00, 16'($urandom));
        else if (pick == 14) begin
            fill_payload($urandom_range(6));
            add_record($urandom_range(1000), $urandom_range(1) ? RT_ESA : RT_ELA, 1'b0);
        end
        else if (pick == 15) add_comment();
        else if (pick == 16) end_line();
        else if (pick == 17) add_read();
        else begin
            fill_payload($urandom_range(1, 6));
            add_record(0, $urandom_range(1) ? RT_SSA : RT_EOF, 1'b0);
        end
    endtask

    initial
    begin
        int ending;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        offering = 1'b0;
        hold_left = 0;
        errors = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        foreach (img_mem[i]) img_mem[i] = 8'hFF;
        foreach (rec_buf[i]) rec_buf[i] = 8'h00;
        rec_hdr = '0;
        n_chars = 0;
        nibble = '0;
        csum = '0;
        phase = PH_START;
        lo_addr = 65536;
        hi_end = 0;
        entry_addr = 0;
        line_no = 1;
        done = 1'b0;
        cr_held = 1'b0;
        final_st = '0;
        final_line = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: blank lines, comments, every record type, bounds, ignored command
        add_read();
        add_char(CH_LF);
        add_char(CH_CR);
        add_char(CH_LF);
        add_comment();
        fill_payload(16);
        add_record(0, RT_DATA, 1'b0);
        fill_payload(16);
        add_record(16'hFFF0, RT_DATA, 1'b0);
        fill_payload(0);
        add_record(16'h1234, RT_DATA, 1'b0);
        add_entry(RT_SSA, 8'h00, 16'h0008);
        add_entry(RT_SLA, 8'h00, 16'h8000);
        add_entry(RT_SSA, 8'h12, 16'h0004);
        fill_payload(2);
        add_record(0, RT_SLA, 1'b0);
        fill_payload(1);
        add_record(0, RT_EOF, 1'b0);
        fill_payload(2);
        add_record(0, RT_ESA, 1'b0);
        fill_payload(2);
        add_record(0, RT_ELA, 1'b0);
        add_item(2'd3, 8'hFF, 16'hFFFF);
        fill_payload(255);
        add_record(16'h4000, RT_DATA, 1'b0);
        add_item(CMD_READ, 8'h00, 16'h0000);
        add_item(CMD_READ, 8'hFF, 16'hFFFF);

        // random lines in groups of varying idling
        for (int grp = 0; grp < 12; grp++) begin
            set_idling(grp);
            if (grp == 5) hold_left = 600;
            if (grp == 8) wait_drained();
            repeat (2) random_line();
            while (text_q.size() > 20) @(posedge clk);
        end

        // closing the text: EOF record, bare end of input, or a malformed line
        ending = $urandom_range(2);
        if (ending == 0) begin
            fill_payload(0);
            add_record(0, RT_EOF, 1'b0);
        end
        else if (ending == 2) begin
            case ($urandom_range(6))
                0: begin fill_payload(4); add_record(0, RT_DATA, 1'b1); end
                1: begin add_char(CH_COLON); add_char("G"); end_line(); end
                2: begin add_char("X"); end_line(); end
                3: begin fill_payload(8); add_record(16'hFFFC, RT_DATA, 1'b0); end
                4: begin fill_payload(2); add_record(0, 8'h06, 1'b0); end
                5: begin add_char(CH_COLON); repeat (530) add_char("0"); end_line(); end
                default: begin add_char(CH_COLON); add_hex(8'h00); add_char("0"); end
            endcase
        end
        add_item(CMD_END, 8'($urandom), 16'($urandom));
        repeat (5) add_char(8'($urandom));
        for (int grp = 0; grp < 4; grp++) begin
            set_idling(grp);
            repeat (20) add_read();
            add_item(CMD_END, 8'($urandom), 16'($urandom));
            while (text_q.size() > 10) @(posedge clk);
        end

        wait_drained();
        repeat (300) @(posedge clk);
        if (errors == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end

endmodule
`default_nettype wire

/* intel_hex_image_loader_core.f */
hdl/ihl_pkg.sv
hdl/ihl_judge.sv
hdl/intel_hex_image_loader_core.sv
tb/sv/intel_hex_image_loader_core_tb.sv
